@@ src/atan2p_pkg.sv @@
// Shared types, constants and helpers for the atan2 polynomial unit.
// No dependencies; used by every module of the block.
package atan2p_pkg;

  // Ratio width: Q0.16 plus one bit for the ratio 1.0
  localparam int unsigned TW = 17;
  localparam int unsigned QBITS = 17;

  // Polynomial coefficients, Q2.16
  localparam logic signed [17:0] K0 = -18'sd1235;
  localparam logic signed [17:0] K1 = 18'sd4588;
  localparam logic signed [17:0] K2 = -18'sd8600;
  localparam logic signed [17:0] K3 = 18'sd13026;
  localparam logic signed [17:0] K4 = -18'sd21844;

  localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;
  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

  // Per-request flags carried alongside the datapath
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic steep;
    logic origin;
  } side_t;

  // Round half up and drop 16 fraction bits
  function automatic logic signed [23:0] rnd16(input logic signed [39:0] v);
    logic signed [39:0] w;
    begin
      w = v + 40'sd32768;
      return w[39:16];
    end
  endfunction

endpackage

@@ src/atan2p_div.sv @@
// Pipelined restoring divider: t = (lo << 16) / hi, one quotient bit per stage.
// Depends on atan2p_pkg.
module atan2p_div #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [W-1:0]          lo_i,
  input  logic [W-1:0]          hi_i,
  input  atan2p_pkg::side_t     side_i,
  output logic                  valid_o,
  output logic [atan2p_pkg::TW-1:0] t_o,
  output atan2p_pkg::side_t     side_o
);
  import atan2p_pkg::*;

  logic [W-1:0]    rem_q  [QBITS];
  logic [W-1:0]    hi_q   [QBITS];
  logic [QBITS-1:0] quo_q [QBITS];
  side_t           side_q [QBITS];
  logic            vld_q  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [W-1:0]     rem_in, hi_in, rem_sh, rem_d;
    logic [QBITS-1:0] quo_in;
    side_t            side_in;
    logic             vld_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = lo_i;
      assign hi_in   = hi_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
      assign rem_sh  = rem_in;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign hi_in   = hi_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
      // remainder stays below hi, so the shift never overflows
      assign rem_sh  = {rem_in[W-2:0], 1'b0};
    end

    // trial subtract
    assign ge    = (rem_sh >= hi_in);
    assign rem_d = ge ? (rem_sh - hi_in) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        hi_q[k]   <= hi_in;
        quo_q[k]  <= {quo_in[QBITS-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QBITS-1];
  assign t_o     = quo_q[QBITS-1];
  assign side_o  = side_q[QBITS-1];

endmodule

@@ src/atan2p_poly.sv @@
// Polynomial pipeline: Horner evaluation of atan(t), octant fold and quadrant fix.
// Depends on atan2p_pkg.
module atan2p_poly (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [atan2p_pkg::TW-1:0] t_i,
  input  atan2p_pkg::side_t         side_i,
  output logic                      valid_o,
  output logic signed [15:0]        angle_o,
  output logic                      undef_o
);
  import atan2p_pkg::*;

  localparam int unsigned NS = 6;

  logic              vld_q  [NS];
  side_t             side_q [NS];
  logic [TW-1:0]     t_q    [NS];
  logic [TW-1:0]     t2_q   [NS-2];
  logic [TW-1:0]     t3_q   [1:4];
  logic signed [17:0] acc_q [1:4];
  logic signed [17:0] p_q;

  logic [2*TW-1:0]     sq_prod;
  logic [2*TW-1:0]     sq_rnd;
  logic [2*TW-1:0]     cube_prod;
  logic [2*TW-1:0]     cube_rnd;
  logic signed [23:0]  h_d [4];
  logic signed [23:0]  p_d;
  logic signed [18:0]  r_sum, r_fold;
  logic signed [18:0]  r_rnd;
  logic signed [15:0]  a_clamp, a_sign, a_d;
  logic signed [15:0]  angle_q;
  logic                undef_q, vout_q;

  // stage 1: t squared
  assign sq_prod = t_i * t_i;
  assign sq_rnd  = sq_prod + (2*TW)'(32768);

  // stage 2: first Horner step and t cubed
  assign h_d[0] = rnd16(40'(K0) * 40'(signed'({1'b0, t2_q[0]})))
                  + 24'(K1);
  assign cube_prod = t_q[0] * t2_q[0];
  assign cube_rnd  = cube_prod + (2*TW)'(32768);

  // stages 3 to 5: remaining Horner steps
  assign h_d[1] = rnd16(40'(acc_q[1]) * 40'(signed'({1'b0, t2_q[1]}))) + 24'(K2);
  assign h_d[2] = rnd16(40'(acc_q[2]) * 40'(signed'({1'b0, t2_q[2]}))) + 24'(K3);
  assign h_d[3] = rnd16(40'(acc_q[3]) * 40'(signed'({1'b0, t2_q[3]}))) + 24'(K4);

  // stage 6: t cubed times polynomial
  assign p_d = rnd16(40'(acc_q[4]) * 40'(signed'({1'b0, t3_q[4]})));

  // stage 7: sum, fold, round to Q3.13, clamp, sign, half-plane and origin to zero
  always_comb begin
    r_sum   = 19'(signed'({1'b0, t_q[5]})) + 19'(p_q);
    r_fold  = side_q[5].steep ? (HALF_PI_Q16 - r_sum) : r_sum;
    r_rnd   = (r_fold + 19'sd4) >>> 3;
    if (r_rnd < 19'sd0) begin
      a_clamp = '0;
    end else if (r_rnd > 19'(HALF_PI_Q13)) begin
      a_clamp = HALF_PI_Q13;
    end else begin
      a_clamp = r_rnd[15:0];
    end
    a_sign = (side_q[5].yneg != side_q[5].xneg) ? -a_clamp : a_clamp;
    if (side_q[5].origin) begin
      a_d = '0;
    end else if (side_q[5].xneg) begin
      a_d = side_q[5].yneg ? (a_sign - PI_Q13) : (a_sign + PI_Q13);
    end else begin
      a_d = a_sign;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) vld_q[i] <= 1'b0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NS; i++) vld_q[i] <= vld_q[i-1];
      vout_q <= vld_q[NS-1];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      t_q[0]    <= t_i;
      t2_q[0]   <= sq_rnd[16 +: TW];
      for (int i = 1; i < NS; i++) begin
        side_q[i] <= side_q[i-1];
        t_q[i]    <= t_q[i-1];
      end
      for (int i = 1; i < NS-2; i++) begin
        t2_q[i] <= t2_q[i-1];
      end
      // t cubed rides along to the final product
      t3_q[1]  <= cube_rnd[16 +: TW];
      t3_q[2]  <= t3_q[1];
      t3_q[3]  <= t3_q[2];
      t3_q[4]  <= t3_q[3];
      acc_q[1] <= h_d[0][17:0];
      acc_q[2] <= h_d[1][17:0];
      acc_q[3] <= h_d[2][17:0];
      acc_q[4] <= h_d[3][17:0];
      p_q      <= p_d[17:0];
      angle_q  <= a_d;
      undef_q  <= side_q[5].origin;
    end
  end

  assign valid_o = vout_q;
  assign angle_o = angle_q;
  assign undef_o = undef_q;

endmodule

@@ src/atan2_polynomial_unit.sv @@
// Top level of the atan2 polynomial unit: input magnitude stage, divider, polynomial.
// Depends on atan2p_pkg, atan2p_div and atan2p_poly.
//
// Usage:
//   Slave channel s_axis_* carries one coordinate pair per request; the
//   master channel m_axis_* returns atan2(y, x) as Q3.13 radians.
//   A request is taken at a rising edge with tvalid and tready both high.
//   The pipeline has one magnitude stage, 17 divider stages (one
//   quotient bit each) and 7 polynomial stages, the last being the output
//   register. Throughput is one request per cycle while the output is not
//   stalled; the divider and the multipliers are fully pipelined.
//   The whole pipeline advances together: when the receiver holds
//   m_axis_tready low with a result waiting, every stage holds and
//   s_axis_tready drops, so nothing is lost or repeated. Bubbles in the
//   pipeline are held in place while the output waits.
//   Reset clears all valid bits; no result is presented until a request
//   has passed through. tuser flags the origin, where the angle reads 0.
module atan2_polynomial_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [COORD_WIDTH-1:0] y_value, [2*COORD_WIDTH-1:COORD_WIDTH] x_value, zero pad
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [15:0] angle
  output logic [15:0] m_axis_tdata,
  // [0] undefined
  output logic [0:0]  m_axis_tuser
);
  import atan2p_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic          adv;
  logic [W-1:0]  y_raw, x_raw, ay, ax;
  logic          yneg, xneg, steep;
  logic          s0_vld_q;
  logic [W-1:0]  lo_q, hi_q;
  side_t         side_q, side_d;
  logic          div_vld;
  logic [TW-1:0] div_t;
  side_t         div_side;
  logic          out_vld;
  logic signed [15:0] angle;
  logic          undef;

  // whole pipeline moves unless a result is stuck at the output
  assign adv           = !out_vld || m_axis_tready;
  assign s_axis_tready = adv;

  // magnitudes and octant
  assign y_raw  = s_axis_tdata[W-1:0];
  assign x_raw  = s_axis_tdata[2*W-1:W];
  assign yneg   = y_raw[W-1];
  assign xneg   = x_raw[W-1];
  assign ay     = yneg ? (W'(0) - y_raw) : y_raw;
  assign ax     = xneg ? (W'(0) - x_raw) : x_raw;
  assign steep  = (ay >= ax);
  assign side_d = '{yneg: yneg, xneg: xneg, steep: steep,
                    origin: (ay == '0) && (ax == '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q   <= steep ? ax : ay;
      hi_q   <= steep ? ay : ax;
      side_q <= side_d;
    end
  end

  atan2p_div #(.W(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s0_vld_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .side_i  (side_q),
    .valid_o (div_vld),
    .t_o     (div_t),
    .side_o  (div_side)
  );

  atan2p_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_vld),
    .t_i     (div_t),
    .side_i  (div_side),
    .valid_o (out_vld),
    .angle_o (angle),
    .undef_o (undef)
  );

  assign m_axis_tvalid   = out_vld;
  assign m_axis_tdata    = angle;
  assign m_axis_tuser[0] = undef;

  // origin result always reads zero
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'h0000))
    else $error("origin result with non-zero angle");

  // angle stays within -pi..pi
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= PI_Q13 &&
                       $signed(m_axis_tdata) >= -PI_Q13))
    else $error("angle out of range");

  // stalled output blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted while output stalled");

endmodule

@@ sim/atan2_polynomial_checker.sv @@
// Checker for the atan2 polynomial unit: watches both stream channels,
// predicts each angle from the accepted coordinate pair and compares.
// Depends on nothing but the unit's port widths.
`timescale 1ns / 1ps

module atan2_polynomial_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] angle;
    logic        undefined;
  } angle_res_t;

  localparam longint CF0 = -1235;
  localparam longint CF1 = 4588;
  localparam longint CF2 = -8600;
  localparam longint CF3 = 13026;
  localparam longint CF4 = -21844;
  localparam longint HALF_PI_FRAC = 102944;
  localparam longint PI_ANG = 25736;
  localparam longint HALF_PI_ANG = 12868;

  angle_res_t angle_q[$];

  // Round half up, arithmetic shift (floor)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic angle_res_t predict_angle(logic [15:0] yv, logic [15:0] xv);
    angle_res_t res;
    logic   yn, xn, steep;
    longint ay, ax, lo, hi, t, t2, acc, t3, r, ang;
    yn = yv[15];
    xn = xv[15];
    ay = yn ? 65536 - longint'(yv) : longint'(yv);
    ax = xn ? 65536 - longint'(xv) : longint'(xv);
    res.undefined = 1'b0;
    if (ay == 0 && ax == 0) begin
      res.angle = '0;
      res.undefined = 1'b1;
      return res;
    end
    if (ay == 0) begin
      res.angle = xn ? 16'(PI_ANG) : 16'd0;
      return res;
    end
    steep = ay >= ax;
    lo = steep ? ax : ay;
    hi = steep ? ay : ax;
    t = (lo << 16) / hi;
    t2 = rnd_shift(t * t, 16);
    acc = rnd_shift(CF0 * t2, 16) + CF1;
    acc = rnd_shift(acc * t2, 16) + CF2;
    acc = rnd_shift(acc * t2, 16) + CF3;
    acc = rnd_shift(acc * t2, 16) + CF4;
    t3 = rnd_shift(t * t2, 16);
    r = t + rnd_shift(t3 * acc, 16);
    if (steep) r = HALF_PI_FRAC - r;
    ang = rnd_shift(r, 3);
    if (ang < 0) ang = 0;
    if (ang > HALF_PI_ANG) ang = HALF_PI_ANG;
    if (yn != xn) ang = -ang;
    if (xn) ang = yn ? ang - PI_ANG : ang + PI_ANG;
    res.angle = 16'(ang);
    return res;
  endfunction

  // Predict on input requests, compare on output requests
  always @(posedge clk_i) begin
    angle_res_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      angle_q.push_back(predict_angle(s_axis_tdata[15:0], s_axis_tdata[31:16]));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_q.size() == 0) begin
        errors_o++;
        $display("%0t: unexpected result angle=%0d undefined=%0b", $time,
                 $signed(m_axis_tdata), m_axis_tuser[0]);
      end else begin
        want = angle_q.pop_front();
        if (want.angle !== m_axis_tdata) begin
          errors_o++;
          $display("%0t: angle expected %0d actual %0d", $time,
                   $signed(want.angle), $signed(m_axis_tdata));
        end
        if (want.undefined !== m_axis_tuser[0]) begin
          errors_o++;
          $display("%0t: undefined expected %0b actual %0b", $time,
                   want.undefined, m_axis_tuser[0]);
        end
      end
    end
    pending_o <= angle_q.size();
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

endmodule

@@ sim/atan2_polynomial_unit_test.sv @@
// Testbench top for the atan2 polynomial unit: clock, reset, coordinate
// stimulus with random idling, watchdog and verdict. Uses the checker module.
`timescale 1ns / 1ps

module atan2_polynomial_unit_test;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] y_value, [31:16] x_value
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] angle
  logic [0:0]  m_axis_tuser;   // [0] undefined
  int          errors;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  atan2_polynomial_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  atan2_polynomial_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no request taken on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one coordinate pair, with optional idle cycles first
  task automatic send_pair(logic [15:0] yv, logic [15:0] xv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {xv, yv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count, int s_pct, int r_pct);
    logic [15:0] yv, xv;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) begin
      yv = rand_coord();
      case ($urandom_range(7))
        0: xv = yv;                 // equal magnitudes
        1: xv = -yv;
        2: xv = 16'd0;              // vertical axis
        default: xv = rand_coord();
      endcase
      if ($urandom_range(9) == 0) yv = 16'd0;
      send_pair(yv, xv);
    end
  endtask

  initial begin
    quiet_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: origin, axes, diagonals, extremes
    send_pair(16'd0, 16'd0);
    send_pair(16'd0, 16'd5);
    send_pair(16'd0, 16'hFFFB);
    send_pair(16'd0, 16'h8000);
    send_pair(16'd7, 16'd0);
    send_pair(16'hFFF9, 16'd0);
    send_pair(16'h8000, 16'd0);
    send_pair(16'd100, 16'd100);
    send_pair(16'hFF9C, 16'd100);
    send_pair(16'd100, 16'hFF9C);
    send_pair(16'hFF9C, 16'hFF9C);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'd1, 16'h7FFF);
    send_pair(16'h7FFF, 16'd1);
    send_pair(16'hFFFF, 16'h8000);
    send_pair(16'h8000, 16'hFFFF);
    send_pair(16'd1, 16'hFFFF);

    // Sender holds off until the pipeline has drained
    s_axis_tvalid <= 1'b0;
    recv_idle_pct = 30;
    while (pending != 0) @(posedge clk_i);

    random_phase(180, 31, 61);
    random_phase(180, 61, 31);
    random_phase(190, 0, 0);
    s_axis_tvalid <= 1'b0;
    recv_idle_pct = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
src/atan2p_pkg.sv
src/atan2p_div.sv
src/atan2p_poly.sv
src/atan2_polynomial_unit.sv
sim/atan2_polynomial_checker.sv
sim/atan2_polynomial_unit_test.sv
